FILE: rtl/core/dcti_pkg.sv
// ----------------------------------------------------------------------------
// dcti_pkg: shared types and constants for the drag coefficient table
// Field widths, operation codes, fixed-point constants and the row layout.
// ----------------------------------------------------------------------------
package dcti_pkg;

    localparam int FUNC_W     = 1;
    localparam int ROW_IDX_W  = 5;
    localparam int BP_W       = 24;
    localparam int COEF_W     = 32;
    localparam int ANG_W      = 18;
    localparam int DEG_W      = 24;
    localparam int ROWS_W     = 6;

    localparam int MAX_ROWS_DEFAULT = 32;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd32;

    // operation codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_EVAL = 1'b1;

    // 180/pi in Q6.24
    localparam int DEG_CONST_W = 30;
    localparam logic [DEG_CONST_W-1:0] DEG_PER_RAD_Q24 = 30'd961263669;
    localparam int DEG_SHIFT  = 24;
    localparam int TERM_SHIFT = 16;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

    // one table row as stored in the RAM
    typedef struct packed {
        logic        [BP_W-1:0]   bp;
        logic signed [COEF_W-1:0] base;
        logic signed [COEF_W-1:0] slope;
    } row_t;

    localparam int ROW_W = $bits(row_t);

endpackage

FILE: rtl/core/dcti_ifs.sv
// ----------------------------------------------------------------------------
// dcti_ifs: request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dcti_req_if;
    import dcti_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [FUNC_W-1:0]    func;
    logic        [ROW_IDX_W-1:0] row_index;
    logic        [BP_W-1:0]      breakpoint_mach;
    logic signed [COEF_W-1:0]    row_base_coefficient;
    logic signed [COEF_W-1:0]    row_slope_coefficient;
    logic        [BP_W-1:0]      flight_mach;
    logic        [ANG_W-1:0]     attack_angle;

    modport source (
        output valid, func, row_index, breakpoint_mach, row_base_coefficient,
               row_slope_coefficient, flight_mach, attack_angle,
        input  ready
    );

    modport sink (
        input  valid, func, row_index, breakpoint_mach, row_base_coefficient,
               row_slope_coefficient, flight_mach, attack_angle,
        output ready
    );
endinterface

interface dcti_rsp_if;
    import dcti_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] drag_coefficient;
    logic signed [COEF_W-1:0] base_drag_coefficient;
    logic        [DEG_W-1:0]  attack_angle_degrees;

    modport source (
        output valid, drag_coefficient, base_drag_coefficient, attack_angle_degrees,
        input  ready
    );

    modport sink (
        input  valid, drag_coefficient, base_drag_coefficient, attack_angle_degrees,
        output ready
    );
endinterface

FILE: rtl/core/dcti_ram.sv
// ----------------------------------------------------------------------------
// dcti_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module dcti_ram #(
    parameter int WIDTH = dcti_pkg::ROW_W,
    parameter int DEPTH = dcti_pkg::MAX_ROWS_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/drag_coefficient_table_interp.sv
// An evaluate beat takes row 0 when the Mach number is below breakpoint 0, the
// last row when it is at or above the last breakpoint, and otherwise scans until
// breakpoint k (k = 1 .. rows-1) is the first above it: one RAM read per row
// scanned plus two restoring divisions. One item at a time.
// Reset clears the sequencer, the response valid and sets rows_in_use to 32;
// the table RAM is not cleared.
// ----------------------------------------------------------------------------
// drag_coefficient_table_interp: drag coefficient by table interpolation
// Load beats fill table rows (Mach breakpoint, base, slope per degree).
// Evaluate beats convert the attack angle to degrees, bracket the Mach
// number by a linear scan of the RAM, interpolate base and slope through a
// shared multiplier and a shared bit-serial divider, and return
// drag = base + degrees * slope, saturated to 32 bits.
// ----------------------------------------------------------------------------
module drag_coefficient_table_interp #(
    parameter int MAX_ROWS = dcti_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dcti_pkg::ROWS_W-1:0]   cfg_wr_data,
    dcti_req_if.sink                      req,
    dcti_rsp_if.source                    rsp
);
    import dcti_pkg::*;

    // table address width, and a width that holds both rows_in_use and MAX_ROWS
    localparam int AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW      = (AW + 1 > ROWS_W) ? AW + 1 : ROWS_W;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = BP_W + 1;
    localparam int MUL_B_W = COEF_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // divider: quotient never exceeds 2^32, numerator below span * 2^33
    localparam int Q_W     = COEF_W + 1;
    localparam int NUM_W   = Q_W + BP_W;
    localparam int CNT_W   = $clog2(Q_W + 1);

    // drag sum width: base plus rounded slope term
    localparam int SUM_W   = PROD_W - TERM_SHIFT + 2;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LAST = 4'd1;   // row n-1 on the read port
    localparam logic [3:0] S_ROW0 = 4'd2;   // row 0 on the read port
    localparam logic [3:0] S_SCAN = 4'd3;   // rows 1.. on the read port
    localparam logic [3:0] S_IMUL = 4'd4;   // offset * column difference
    localparam logic [3:0] S_DSET = 4'd5;   // magnitude + half span, load divider
    localparam logic [3:0] S_DIV  = 4'd6;   // one quotient bit per cycle
    localparam logic [3:0] S_IADD = 4'd7;   // low column + signed quotient
    localparam logic [3:0] S_TERM = 4'd8;   // degrees * slope
    localparam logic [3:0] S_SUM  = 4'd9;   // round, add, saturate, present

    logic [3:0]                state_reg, state_next;
    logic [ROWS_W-1:0]         rows_reg;
    logic [BP_W-1:0]           m_reg, m_next;
    logic [AW-1:0]             last_reg, last_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [DEG_W-1:0]          deg_reg, deg_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    row_t                      lo_reg, lo_next;
    row_t                      hi_reg, hi_next;
    logic                      slope_pass_reg, slope_pass_next;
    logic signed [COEF_W-1:0]  base_reg, base_next;
    logic signed [COEF_W-1:0]  slope_reg, slope_next;
    logic [BP_W-1:0]           rem_reg, rem_next;
    logic [Q_W-1:0]            quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      neg_reg, neg_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [COEF_W-1:0]  out_drag_reg, out_drag_next;
    logic signed [COEF_W-1:0]  out_base_reg, out_base_next;
    logic [DEG_W-1:0]          out_deg_reg, out_deg_next;

    logic                      req_acc;
    logic                      eval_acc;
    logic [CW-1:0]             rows_ext;
    logic [AW-1:0]             last_row;

    logic                      ram_wr_en;
    logic [AW-1:0]             ram_wr_addr;
    row_t                      ram_wr_row;
    logic                      ram_rd_en;
    logic [AW-1:0]             ram_rd_addr;
    logic [ROW_W-1:0]          ram_rd_data;
    row_t                      rd_row;
    logic                      m_below;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic [PROD_W-1:0]         prod_abs;
    logic [BP_W-1:0]           span;
    logic [NUM_W-1:0]          numer;
    logic [BP_W:0]             div_shift;
    logic [BP_W:0]             div_diff;
    logic                      div_ge;
    logic signed [COEF_W-1:0]  col_lo;
    logic signed [COEF_W-1:0]  col_hi;
    logic signed [Q_W:0]       quo_signed;
    logic signed [Q_W:0]       interp_sum;
    logic [PROD_W-1:0]         deg_sum;
    logic [PROD_W-1:0]         term_sum;
    logic signed [SUM_W-1:0]   term_signed;
    logic signed [SUM_W-1:0]   drag_wide;
    logic                      sat_hi;
    logic                      sat_lo;
    logic signed [COEF_W-1:0]  drag_sat;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign eval_acc  = req_acc && (req.func == FUNC_EVAL);

    assign rsp.valid                 = out_valid_reg;
    assign rsp.drag_coefficient      = out_drag_reg;
    assign rsp.base_drag_coefficient = out_base_reg;
    assign rsp.attack_angle_degrees  = out_deg_reg;

    // last row in use: rows_in_use clamped to 2 .. MAX_ROWS, minus one
    assign rows_ext = CW'(rows_reg);

    always_comb
    begin
        if (rows_ext < CW'(2))
        begin
            last_row = AW'(1);
        end
        else if (rows_ext > CW'(MAX_ROWS))
        begin
            last_row = AW'(MAX_ROWS - 1);
        end
        else
        begin
            last_row = AW'(rows_ext - CW'(1));
        end
    end

    // ------------------------------------------------------------------
    // table RAM: one row per entry, loads write straight from the beat
    // ------------------------------------------------------------------
    assign ram_wr_en        = req_acc && (req.func == FUNC_LOAD)
                              && (int'(req.row_index) < MAX_ROWS);
    assign ram_wr_addr      = AW'(req.row_index);
    assign ram_wr_row.bp    = req.breakpoint_mach;
    assign ram_wr_row.base  = req.row_base_coefficient;
    assign ram_wr_row.slope = req.row_slope_coefficient;

    // the read address runs one step ahead: row 0, then the last row, then the scan
    always_comb
    begin
        case (state_reg)
            S_IDLE:  ram_rd_addr = '0;
            S_ROW0:  ram_rd_addr = last_reg;
            S_LAST:  ram_rd_addr = AW'(1);
            S_SCAN:  ram_rd_addr = idx_reg + AW'(1);
            default: ram_rd_addr = '0;
        endcase
    end

    assign ram_rd_en = eval_acc || (state_reg == S_LAST) || (state_reg == S_ROW0)
                       || (state_reg == S_SCAN);

    dcti_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ROWS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_row),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_row  = row_t'(ram_rd_data);
    assign m_below = (m_reg < rd_row.bp);

    // ------------------------------------------------------------------
    // shared multiplier: angle conversion, interpolation, slope term
    // ------------------------------------------------------------------
    assign col_lo = slope_pass_reg ? lo_reg.slope : lo_reg.base;
    assign col_hi = slope_pass_reg ? hi_reg.slope : hi_reg.base;
    assign span   = hi_reg.bp - lo_reg.bp;

    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                mul_a = $signed({{(MUL_A_W - ANG_W){1'b0}}, req.attack_angle});
                mul_b = $signed({{(MUL_B_W - DEG_CONST_W){1'b0}}, DEG_PER_RAD_Q24});
            end
            S_IMUL:
            begin
                mul_a = $signed({1'b0, m_reg - lo_reg.bp});
                mul_b = $signed({{2{col_hi[COEF_W-1]}}, col_hi})
                        - $signed({{2{col_lo[COEF_W-1]}}, col_lo});
            end
            S_TERM:
            begin
                mul_a = $signed({{(MUL_A_W - DEG_W){1'b0}}, deg_reg});
                mul_b = $signed({{2{slope_reg[COEF_W-1]}}, slope_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // rounding, divider step and result arithmetic
    // ------------------------------------------------------------------
    assign prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // round to nearest, ties away from zero: (|p| + span/2) / span
    assign numer = NUM_W'(prod_abs) + NUM_W'(span >> 1);

    // restoring step; remainder stays below span so the difference fits
    assign div_shift = {rem_reg, quo_reg[Q_W-1]};
    assign div_ge    = (div_shift >= {1'b0, span});
    assign div_diff  = div_shift - {1'b0, span};

    assign quo_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign interp_sum = $signed({{2{col_lo[COEF_W-1]}}, col_lo}) + quo_signed;

    assign deg_sum  = prod_abs + (PROD_W'(1) << (DEG_SHIFT - 1));
    assign term_sum = prod_abs + (PROD_W'(1) << (TERM_SHIFT - 1));

    // rounded magnitude zero-extends into the sum width, so its top bit is clear
    assign term_signed = prod_reg[PROD_W-1]
        ? -$signed(SUM_W'(term_sum[PROD_W-1:TERM_SHIFT]))
        :  $signed(SUM_W'(term_sum[PROD_W-1:TERM_SHIFT]));
    assign drag_wide = $signed({{(SUM_W - COEF_W){base_reg[COEF_W-1]}}, base_reg})
                       + term_signed;

    // saturate when the upper bits are not a sign extension of bit 31
    assign sat_hi   = !drag_wide[SUM_W-1] && (|drag_wide[SUM_W-2:COEF_W-1]);
    assign sat_lo   =  drag_wide[SUM_W-1] && !(&drag_wide[SUM_W-2:COEF_W-1]);
    assign drag_sat = sat_hi ? COEF_MAX : (sat_lo ? COEF_MIN : drag_wide[COEF_W-1:0]);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        m_next          = m_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        deg_next        = deg_reg;
        prod_next       = prod_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        slope_pass_next = slope_pass_reg;
        base_next       = base_reg;
        slope_next      = slope_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        out_drag_next   = out_drag_reg;
        out_base_next   = out_base_reg;
        out_deg_next    = out_deg_reg;
        out_valid_next  = (out_valid_reg && rsp.ready) ? 1'b0 : out_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (eval_acc)
                begin
                    m_next     = req.flight_mach;
                    last_next  = last_row;
                    prod_next  = mul_p;
                    state_next = S_ROW0;
                end
            end
            S_ROW0:
            begin
                deg_next = deg_sum[DEG_SHIFT +: DEG_W];
                lo_next  = rd_row;
                if (m_below)
                begin
                    // below the table: row 0, checked before the top end
                    base_next  = rd_row.base;
                    slope_next = rd_row.slope;
                    state_next = S_TERM;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!m_below)
                begin
                    // at or above the last breakpoint: last row, no interpolation
                    base_next  = rd_row.base;
                    slope_next = rd_row.slope;
                    state_next = S_TERM;
                end
                else
                begin
                    idx_next   = AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // first breakpoint above m closes the bracket
                if (m_below || (idx_reg == last_reg))
                begin
                    hi_next         = rd_row;
                    slope_pass_next = 1'b0;
                    state_next      = S_IMUL;
                end
                else
                begin
                    lo_next  = rd_row;
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_IMUL:
            begin
                prod_next  = mul_p;
                state_next = S_DSET;
            end
            S_DSET:
            begin
                neg_next   = prod_reg[PROD_W-1];
                rem_next   = numer[NUM_W-1:Q_W];
                quo_next   = numer[Q_W-1:0];
                cnt_next   = CNT_W'(Q_W);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = div_ge ? div_diff[BP_W-1:0] : div_shift[BP_W-1:0];
                quo_next = {quo_reg[Q_W-2:0], div_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_IADD;
                end
            end
            S_IADD:
            begin
                if (!slope_pass_reg)
                begin
                    base_next       = interp_sum[COEF_W-1:0];
                    slope_pass_next = 1'b1;
                    state_next      = S_IMUL;
                end
                else
                begin
                    slope_next = interp_sum[COEF_W-1:0];
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                prod_next  = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // hold here while an earlier response still waits
                if (!out_valid_reg || rsp.ready)
                begin
                    out_drag_next  = drag_sat;
                    out_base_next  = base_reg;
                    out_deg_next   = deg_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_reg      <= ROWS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                rows_reg <= cfg_wr_data;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        m_reg          <= m_next;
        last_reg       <= last_next;
        idx_reg        <= idx_next;
        deg_reg        <= deg_next;
        prod_reg       <= prod_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        slope_pass_reg <= slope_pass_next;
        base_reg       <= base_next;
        slope_reg      <= slope_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        neg_reg        <= neg_next;
        out_drag_reg   <= out_drag_next;
        out_base_reg   <= out_base_next;
        out_deg_reg    <= out_deg_next;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for drag_coefficient_table_interp
// Loads table rows and sends evaluate beats over the request channel. A local
// interpolation predictor, or a typed expectation, queues the expected result of
// each evaluate beat. Every response beat is compared field by field with the
// oldest entry. A typed stimulus table runs first, then randomized phases, each
// with its own rows_in_use setting.
// ----------------------------------------------------------------------------
module tb;
    import dcti_pkg::*;

    localparam int TBL_ROWS     = MAX_ROWS_DEFAULT;
    localparam int ANGLE_PI     = 205887;      // pi in Q2.16
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LOAD_SETTLE  = 8;           // a load beat may still be retiring
    localparam int TAIL_CYCLES  = 120;         // room for the slowest evaluate
    localparam int PHASE_ITEMS  = 135;

    typedef enum logic {STEP_ROWS_REG, STEP_BEAT} step_kind_e;

    // one response beat
    typedef struct packed {
        logic signed [COEF_W-1:0] drag;
        logic signed [COEF_W-1:0] base;
        logic        [DEG_W-1:0]  deg;
    } drag_result_t;

    // one row of stimulus: a rows_in_use write or a request beat
    typedef struct packed {
        step_kind_e               kind;
        logic [ROWS_W-1:0]        rows_val;
        logic [FUNC_W-1:0]        func;
        logic [ROW_IDX_W-1:0]     row;
        logic [BP_W-1:0]          bp;
        logic [COEF_W-1:0]        base;
        logic [COEF_W-1:0]        slope;
        logic [BP_W-1:0]          mach;
        logic [ANG_W-1:0]         angle;
        logic                     known;   // want holds a typed expectation
        drag_result_t             want;
    } aero_step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [ROWS_W-1:0]    cfg_wr_data;

    dcti_req_if req_ch ();
    dcti_rsp_if rsp_ch ();

    drag_coefficient_table_interp uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // predictor state: shadow table and rows_in_use
    row_t               tbl [TBL_ROWS];
    logic [ROWS_W-1:0]  rows_reg;

    drag_result_t       drag_expected [$];
    aero_step_t         directed_plan [$];

    int   fails;
    bit   no_idle;          // set for a stretch of back-to-back beats on both sides
    int   cycles;

    logic [ROWS_W-1:0] rows_sweep [11] = '{6'd2, 6'd32, 6'd0, 6'd63, 6'd1, 6'd7,
                                           6'd33, 6'd31, 6'd16, 6'd3, 6'd5};

    // ------------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // division rounded to nearest, ties away from zero; den > 0
    function automatic longint div_nearest(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic int rows_active(logic [ROWS_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > TBL_ROWS)
            return TBL_ROWS;
        return int'(v);
    endfunction

    function automatic longint column_at(int i, bit slope_col);
        return slope_col ? longint'($signed(tbl[i].slope)) : longint'($signed(tbl[i].base));
    endfunction

    // linear interpolation of one column, clamped at both table ends
    function automatic longint interp_column(longint m, int n, bit slope_col);
        int     hi;
        bit     found;
        longint span;
        longint off;
        longint lo_v;
        if (m < longint'(tbl[0].bp))
            return column_at(0, slope_col);
        if (m >= longint'(tbl[n-1].bp))
            return column_at(n - 1, slope_col);
        // first breakpoint strictly above m; works for non-rising rows too
        hi    = n - 1;
        found = 1'b0;
        for (int i = 1; i < n; i++)
        begin
            if (!found && m < longint'(tbl[i].bp))
            begin
                hi    = i;
                found = 1'b1;
            end
        end
        span = longint'(tbl[hi].bp) - longint'(tbl[hi-1].bp);
        off  = m - longint'(tbl[hi-1].bp);
        lo_v = column_at(hi - 1, slope_col);
        return lo_v + div_nearest(off * (column_at(hi, slope_col) - lo_v), span);
    endfunction

    function automatic drag_result_t predict_drag(logic [BP_W-1:0] mach,
                                                  logic [ANG_W-1:0] angle);
        drag_result_t r;
        int     n;
        longint deg;
        longint base;
        longint slope;
        longint drag;
        n     = rows_active(rows_reg);
        deg   = (longint'(angle) * longint'(DEG_PER_RAD_Q24)
                 + (longint'(1) << (DEG_SHIFT - 1))) >>> DEG_SHIFT;
        base  = interp_column(longint'(mach), n, 1'b0);
        slope = interp_column(longint'(mach), n, 1'b1);
        drag  = base + div_nearest(deg * slope, longint'(1) << TERM_SHIFT);
        if (drag > longint'(COEF_MAX))
            drag = longint'(COEF_MAX);
        if (drag < longint'(COEF_MIN))
            drag = longint'(COEF_MIN);
        r.drag = drag[COEF_W-1:0];
        r.base = base[COEF_W-1:0];
        r.deg  = deg[DEG_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // Drive one beat and wait for it to be taken. valid stays high into the
    // next beat when no gap is drawn, so it is never lowered and raised in one step.
    task automatic send_beat(input aero_step_t s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid                 <= 1'b1;
        req_ch.func                  <= s.func;
        req_ch.row_index             <= s.row;
        req_ch.breakpoint_mach       <= s.bp;
        req_ch.row_base_coefficient  <= s.base;
        req_ch.row_slope_coefficient <= s.slope;
        req_ch.flight_mach           <= s.mach;
        req_ch.attack_angle          <= s.angle;
        do
            @(posedge clk);
        while (!req_ch.ready);
        // beat taken at this edge: update the shadow table or queue the answer
        if (s.func == FUNC_LOAD)
        begin
            tbl[s.row].bp    = s.bp;
            tbl[s.row].base  = s.base;
            tbl[s.row].slope = s.slope;
        end
        else if (s.known)
            drag_expected.push_back(s.want);
        else
            drag_expected.push_back(predict_drag(s.mach, s.angle));
    endtask

    // stop sending and wait until every queued answer has come back
    task automatic drain_pending();
        req_ch.valid <= 1'b0;
        while (drag_expected.size() != 0)
            @(posedge clk);
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    task automatic write_rows_reg(input logic [ROWS_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        rows_reg     = v;
    endtask

    // ------------------------------------------------------------------------
    // response side: random stalls, field by field compare
    // ------------------------------------------------------------------------
    initial
    begin
        drag_result_t want;
        int stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rst_n));
            if (drag_expected.size() == 0)
            begin
                $error("response beat with nothing pending: drag=%h base=%h deg=%h",
                       rsp_ch.drag_coefficient, rsp_ch.base_drag_coefficient,
                       rsp_ch.attack_angle_degrees);
                fails++;
            end
            else
            begin
                want = drag_expected.pop_front();
                if (rsp_ch.drag_coefficient !== want.drag)
                begin
                    $error("drag_coefficient: expected %h, got %h",
                           want.drag, rsp_ch.drag_coefficient);
                    fails++;
                end
                if (rsp_ch.base_drag_coefficient !== want.base)
                begin
                    $error("base_drag_coefficient: expected %h, got %h",
                           want.base, rsp_ch.base_drag_coefficient);
                    fails++;
                end
                if (rsp_ch.attack_angle_degrees !== want.deg)
                begin
                    $error("attack_angle_degrees: expected %h, got %h",
                           want.deg, rsp_ch.attack_angle_degrees);
                    fails++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 32'h3FFFF) - 32'h20000;    // near zero
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // data fields random, func set to evaluate; callers pick func and the fields that matter
    function automatic aero_step_t noise_step();
        aero_step_t s;
        s.kind     = STEP_BEAT;
        s.rows_val = '0;
        s.func     = FUNC_EVAL;
        s.row      = ROW_IDX_W'($urandom);
        s.bp       = BP_W'($urandom);
        s.base     = rand_coef();
        s.slope    = rand_coef();
        s.mach     = BP_W'($urandom);
        s.angle    = ($urandom_range(0, 3) == 0) ? ANG_W'($urandom)
                                                 : ANG_W'($urandom_range(0, ANGLE_PI));
        s.known    = 1'b0;
        s.want     = '0;
        return s;
    endfunction

    // Mach numbers around the loaded breakpoints: on, just off, between, ends
    function automatic logic [BP_W-1:0] pick_mach(int n);
        int     k;
        longint a;
        longint b;
        longint v;
        k = $urandom_range(0, n - 1);
        a = tbl[k].bp;
        b = tbl[(k + 1 < n) ? k + 1 : k].bp;
        case ($urandom_range(0, 7))
            0:       v = $urandom;
            1:       v = a;
            2:       v = a - 1;
            3:       v = a + 1;
            4:       v = $urandom_range(int'(a), int'(b));
            5:       v = 0;
            6:       v = 24'hFF_FFFF;
            default: v = $urandom_range(tbl[0].bp, tbl[n-1].bp);
        endcase
        return v[BP_W-1:0];
    endfunction

    function automatic aero_step_t blank_step();
        aero_step_t s;
        s = '0;
        s.kind = STEP_BEAT;
        return s;
    endfunction

    task automatic plan_rows(input logic [ROWS_W-1:0] v);
        aero_step_t s;
        s          = blank_step();
        s.kind     = STEP_ROWS_REG;
        s.rows_val = v;
        directed_plan.push_back(s);
    endtask

    task automatic plan_load(input int r, input logic [BP_W-1:0] bp,
                             input logic [COEF_W-1:0] base, input logic [COEF_W-1:0] slope);
        aero_step_t s;
        s       = blank_step();
        s.func  = FUNC_LOAD;
        s.row   = ROW_IDX_W'(r);
        s.bp    = bp;
        s.base  = base;
        s.slope = slope;
        directed_plan.push_back(s);
    endtask

    task automatic plan_eval(input logic [BP_W-1:0] mach, input logic [ANG_W-1:0] angle);
        aero_step_t s;
        s       = blank_step();
        s.func  = FUNC_EVAL;
        s.mach  = mach;
        s.angle = angle;
        directed_plan.push_back(s);
    endtask

    task automatic plan_eval_known(input logic [BP_W-1:0] mach, input logic [ANG_W-1:0] angle,
                                   input logic [COEF_W-1:0] drag,
                                   input logic [COEF_W-1:0] base,
                                   input logic [DEG_W-1:0] deg);
        aero_step_t s;
        s        = blank_step();
        s.func   = FUNC_EVAL;
        s.mach   = mach;
        s.angle  = angle;
        s.known  = 1'b1;
        s.want.drag = drag;
        s.want.base = base;
        s.want.deg  = deg;
        directed_plan.push_back(s);
    endtask

    // One randomized phase: new rows_in_use, reload the rows in use with a
    // mostly rising breakpoint set, then a mix of evaluates and stray loads.
    task automatic run_phase(input logic [ROWS_W-1:0] rows_val, input int n_items);
        aero_step_t s;
        int n;
        int mode;
        int prev;
        int room;
        int step;
        int lo_step;
        drain_pending();
        write_rows_reg(rows_val);
        n       = rows_active(rows_val);
        no_idle = ($urandom_range(0, 3) == 0);
        mode    = $urandom_range(0, 8);     // 7: repeated breakpoints, 8: unordered
        prev    = 0;
        for (int i = 0; i < n; i++)
        begin
            s      = noise_step();
            s.func = FUNC_LOAD;
            s.row  = ROW_IDX_W'(i);
            if (mode == 8)
                s.bp = BP_W'($urandom);
            else
            begin
                room    = (32'hFF_FFFF - prev) / (n - i);
                room    = room >> $urandom_range(0, 12);   // dense tables now and then
                lo_step = (mode == 7 || i == 0) ? 0 : 1;
                step    = (room > lo_step) ? $urandom_range(lo_step, room) : lo_step;
                prev    = prev + step;
                if (prev > 32'hFF_FFFF)
                    prev = 32'hFF_FFFF;
                s.bp = BP_W'(prev);
            end
            send_beat(s);
        end
        for (int j = 0; j < n_items; j++)
        begin
            s = noise_step();
            if ($urandom_range(0, 19) < 3)
                s.func = FUNC_LOAD;         // may also break the ordering of rows in use
            else
            begin
                s.func = FUNC_EVAL;
                s.mach = pick_mach(n);
            end
            if ($urandom_range(0, 49) == 0)
                no_idle = ~no_idle;
            send_beat(s);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        fails    = 0;
        no_idle  = 1'b0;
        rows_reg = ROWS_RESET;
        foreach (tbl[i])
            tbl[i] = '0;

        rst_n                        <= 1'b0;
        cfg_wr_en                    <= 1'b0;
        cfg_wr_data                  <= '0;
        req_ch.valid                 <= 1'b0;
        req_ch.func                  <= FUNC_LOAD;
        req_ch.row_index             <= '0;
        req_ch.breakpoint_mach       <= '0;
        req_ch.row_base_coefficient  <= '0;
        req_ch.row_slope_coefficient <= '0;
        req_ch.flight_mach           <= '0;
        req_ch.attack_angle          <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. With rows_in_use at its reset value of 32, Mach
        // numbers off either table end touch only rows 0 and 31.
        plan_load(0, 24'h01_0000, 32'h0001_0000, 32'h0000_0000);
        plan_load(31, 24'h02_0000, 32'h0005_0000, 32'h0000_8000);
        plan_eval_known(24'h00_0000, 18'h0, 32'h0001_0000, 32'h0001_0000, 24'h0);
        plan_eval_known(24'hFF_FFFF, 18'h0, 32'h0005_0000, 32'h0005_0000, 24'h0);
        // zero rows acts as two
        plan_rows(6'd0);
        plan_load(1, 24'h03_0000, 32'h0003_0000, 32'h0001_0000);
        plan_eval_known(24'h03_0000, 18'h0, 32'h0003_0000, 32'h0003_0000, 24'h0);
        plan_eval(24'h02_0000, 18'h1_0000);
        plan_eval(24'h02_FFFF, 18'h3_FFFF);              // angle above pi, all ones
        plan_eval(24'h01_0000, 18'(ANGLE_PI));           // exactly on breakpoint 0
        // one row acts as two; full-scale coefficients drive the saturation
        plan_rows(6'd1);
        plan_load(0, 24'h00_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        plan_load(1, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        plan_eval(24'h00_0000, 18'(ANGLE_PI));           // positive clip
        plan_eval(24'hFF_FFFF, 18'h1_5555);
        plan_load(0, 24'h00_0000, 32'h8000_0000, 32'h8000_0000);
        plan_load(1, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        plan_eval(24'h00_0000, 18'(ANGLE_PI));           // negative clip
        plan_eval(24'h80_0000, 18'h0_1234);              // widest span, widest delta
        // breakpoints not rising: row 1 sits below row 0
        plan_rows(6'd3);
        plan_load(0, 24'h04_0000, 32'h0001_0000, 32'h0000_0100);
        plan_load(1, 24'h01_0000, 32'h0002_0000, 32'hFFFF_0000);
        plan_load(2, 24'h08_0000, 32'hFFFE_0000, 32'h0003_0000);
        plan_eval(24'h06_0000, 18'h0_8000);
        plan_eval_known(24'h02_0000, 18'h0, 32'h0001_0000, 32'h0001_0000, 24'h0);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == STEP_ROWS_REG)
            begin
                drain_pending();
                write_rows_reg(directed_plan[i].rows_val);
            end
            else
                send_beat(directed_plan[i]);
        end

        // randomized phases over the rows_in_use sweep, last one random
        foreach (rows_sweep[i])
            run_phase((i == $size(rows_sweep) - 1) ? 6'($urandom) : rows_sweep[i],
                      PHASE_ITEMS);

        drain_pending();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
